[design/crcd_pkg.sv]
// ----------------------------------------------------------------------------
// crcd_pkg
// Shared types, widths and the CRC-16/MODBUS byte update for the deframer.
// ----------------------------------------------------------------------------
package crcd_pkg;

    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 6;
    localparam int IDX_W   = 5;
    localparam int CRC_W   = 16;
    localparam int CFG_IDX_W = 4;

    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

    localparam logic [BYTE_W-1:0] FIRST_SOF_RESET  = 8'hAA;
    localparam logic [BYTE_W-1:0] SECOND_SOF_RESET = 8'h55;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SOF  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_SOF = 4'd1;

    // Result tdata: id, command, length, payload, index, padded to bytes
    localparam int OUT_FIELDS_W = 2 * BYTE_W + LEN_W + BYTE_W + IDX_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Handoff of a good frame from the parser to the emitter
    typedef struct packed {
        logic              start;
        logic [BYTE_W-1:0] id;
        logic [BYTE_W-1:0] command;
        logic [LEN_W-1:0]  length;
    } job_t;

    // Reflected CRC-16 update with one byte, LSB first
    function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[design/crc_checked_packet_deframer.sv]
// ----------------------------------------------------------------------------
// crc_checked_packet_deframer
// Start-byte framed packet receiver with CRC-16/MODBUS check.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while a frame is being received. A frame is
// two start bytes, id, command, length, payload and a little-endian CRC over
// id through payload. Payload bytes go into a buffer memory as they arrive;
// on a good frame's last CRC byte the input stalls (s_tready low) while the
// emitter reads the buffer back. Each result takes a buffer read and a load
// of the output register, and is then offered on m_tvalid until m_tready
// takes it; a zero-length frame gives a single result with no buffer read.
// Oversized or bad-CRC frames give no result and never stall the input. The
// start bytes are written through the cfg port, which is always ready.
// ----------------------------------------------------------------------------
module crc_checked_packet_deframer #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [crcd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [crcd_pkg::BYTE_W-1:0]      cfg_data,
    // received bytes
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [crcd_pkg::BYTE_W-1:0]      s_tdata,   // [7:0] rx_byte
    // results
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [7:0] packet_id, [15:8] packet_command, [21:16] packet_length,
    // [29:22] payload_byte, [34:30] byte_index, upper bits zero
    output logic [crcd_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                             m_tlast    // last_of_packet
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int PAD_W = crcd_pkg::OUT_TDATA_W - crcd_pkg::OUT_FIELDS_W;

    logic [crcd_pkg::BYTE_W-1:0] first_sof_reg, second_sof_reg;
    logic                        in_accept;
    logic                        busy;
    logic                        wr_en, rd_en;
    logic [AW-1:0]               wr_addr, rd_addr;
    logic [crcd_pkg::BYTE_W-1:0] wr_data, rd_data;
    crcd_pkg::job_t              job;
    logic [crcd_pkg::BYTE_W-1:0] out_id, out_command, out_payload;
    logic [crcd_pkg::LEN_W-1:0]  out_length;
    logic [crcd_pkg::IDX_W-1:0]  out_index;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_sof_reg  <= crcd_pkg::FIRST_SOF_RESET;
            second_sof_reg <= crcd_pkg::SECOND_SOF_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                crcd_pkg::CFG_FIRST_SOF:  first_sof_reg  <= cfg_data;
                crcd_pkg::CFG_SECOND_SOF: second_sof_reg <= cfg_data;
                default: ;  // drop writes to unknown registers
            endcase
        end
    end

    assign s_tready  = !busy;
    assign in_accept = s_tvalid && s_tready;

    crcd_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .AW          (AW)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_accept  (in_accept),
        .in_byte    (s_tdata),
        .first_sof  (first_sof_reg),
        .second_sof (second_sof_reg),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .job        (job)
    );

    crcd_payload_ram #(
        .DEPTH (MAX_PAYLOAD),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    crcd_emitter #(
        .AW (AW)
    ) u_emitter (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .job         (job),
        .busy        (busy),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_id      (out_id),
        .out_command (out_command),
        .out_length  (out_length),
        .out_payload (out_payload),
        .out_index   (out_index),
        .out_last    (m_tlast)
    );

    assign m_tdata = {{PAD_W{1'b0}}, out_index, out_payload, out_length,
                      out_command, out_id};

endmodule

[design/crcd_payload_ram.sv]
// ----------------------------------------------------------------------------
// crcd_payload_ram
// Payload buffer: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module crcd_payload_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [crcd_pkg::BYTE_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [crcd_pkg::BYTE_W-1:0] rd_data
);

    logic [crcd_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [crcd_pkg::BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/crcd_parser.sv]
// ----------------------------------------------------------------------------
// crcd_parser
// Start-byte hunt, header capture, payload write and running CRC check.
// ----------------------------------------------------------------------------
module crcd_parser #(
    parameter int MAX_PAYLOAD = 32,
    parameter int AW          = 5
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_accept,
    input  logic [crcd_pkg::BYTE_W-1:0] in_byte,
    input  logic [crcd_pkg::BYTE_W-1:0] first_sof,
    input  logic [crcd_pkg::BYTE_W-1:0] second_sof,
    output logic                        wr_en,
    output logic [AW-1:0]               wr_addr,
    output logic [crcd_pkg::BYTE_W-1:0] wr_data,
    output crcd_pkg::job_t              job
);

    localparam logic [2:0] PH_SOF1  = 3'd0;
    localparam logic [2:0] PH_SOF2  = 3'd1;
    localparam logic [2:0] PH_ID    = 3'd2;
    localparam logic [2:0] PH_CMD   = 3'd3;
    localparam logic [2:0] PH_LEN   = 3'd4;
    localparam logic [2:0] PH_DATA  = 3'd5;
    localparam logic [2:0] PH_CRCLO = 3'd6;
    localparam logic [2:0] PH_CRCHI = 3'd7;

    logic [2:0]                        phase_reg, phase_next;
    logic [crcd_pkg::BYTE_W-1:0]       id_reg, id_next;
    logic [crcd_pkg::BYTE_W-1:0]       cmd_reg, cmd_next;
    logic [crcd_pkg::LEN_W-1:0]        len_reg, len_next;
    logic [crcd_pkg::LEN_W-1:0]        count_reg, count_next;
    logic [crcd_pkg::CRC_W-1:0]        crc_reg, crc_next;
    logic [crcd_pkg::BYTE_W-1:0]       crc_lo_reg, crc_lo_next;
    logic [crcd_pkg::CRC_W-1:0]        crc_fed;
    logic [crcd_pkg::LEN_W-1:0]        count_inc;
    logic                              crc_good;

    assign crc_fed   = crcd_pkg::crc_feed(crc_reg, in_byte);
    assign count_inc = count_reg + 1'b1;
    assign crc_good  = ({in_byte, crc_lo_reg} == crc_reg);

    always_comb begin
        phase_next  = phase_reg;
        id_next     = id_reg;
        cmd_next    = cmd_reg;
        len_next    = len_reg;
        count_next  = count_reg;
        crc_next    = crc_reg;
        crc_lo_next = crc_lo_reg;
        wr_en       = 1'b0;
        job.start   = 1'b0;
        job.id      = id_reg;
        job.command = cmd_reg;
        job.length  = len_reg;
        if (in_accept) begin
            unique case (phase_reg)
                PH_SOF1: begin
                    if (in_byte == first_sof) begin
                        phase_next = PH_SOF2;
                    end
                end
                PH_SOF2: begin
                    // second start byte wins when both start bytes are equal
                    if (in_byte == second_sof) begin
                        phase_next = PH_ID;
                        crc_next   = crcd_pkg::CRC_INIT;
                    end else if (in_byte != first_sof) begin
                        phase_next = PH_SOF1;
                    end
                end
                PH_ID: begin
                    id_next    = in_byte;
                    crc_next   = crc_fed;
                    phase_next = PH_CMD;
                end
                PH_CMD: begin
                    cmd_next   = in_byte;
                    crc_next   = crc_fed;
                    phase_next = PH_LEN;
                end
                PH_LEN: begin
                    crc_next = crc_fed;
                    if (in_byte > crcd_pkg::BYTE_W'(MAX_PAYLOAD)) begin
                        phase_next = PH_SOF1;
                    end else begin
                        len_next   = in_byte[crcd_pkg::LEN_W-1:0];
                        count_next = '0;
                        phase_next = (in_byte == '0) ? PH_CRCLO : PH_DATA;
                    end
                end
                PH_DATA: begin
                    wr_en      = 1'b1;
                    crc_next   = crc_fed;
                    count_next = count_inc;
                    if (count_inc >= len_reg) begin
                        phase_next = PH_CRCLO;
                    end
                end
                PH_CRCLO: begin
                    crc_lo_next = in_byte;
                    phase_next  = PH_CRCHI;
                end
                PH_CRCHI: begin
                    phase_next = PH_SOF1;
                    job.start  = crc_good;
                end
                default: begin
                    phase_next = PH_SOF1;
                end
            endcase
        end
    end

    assign wr_addr     = count_reg[AW-1:0];
    assign wr_data     = in_byte;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_SOF1;
            id_reg     <= '0;
            cmd_reg    <= '0;
            len_reg    <= '0;
            count_reg  <= '0;
            crc_reg    <= crcd_pkg::CRC_INIT;
            crc_lo_reg <= '0;
        end else begin
            phase_reg  <= phase_next;
            id_reg     <= id_next;
            cmd_reg    <= cmd_next;
            len_reg    <= len_next;
            count_reg  <= count_next;
            crc_reg    <= crc_next;
            crc_lo_reg <= crc_lo_next;
        end
    end

endmodule

[design/crcd_emitter.sv]
// ----------------------------------------------------------------------------
// crcd_emitter
// Reads a good frame's payload back from the buffer, one result per byte, or a single result for an empty payload.
// ----------------------------------------------------------------------------
module crcd_emitter #(
    parameter int AW = 5
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  crcd_pkg::job_t              job,
    output logic                        busy,
    output logic                        rd_en,
    output logic [AW-1:0]               rd_addr,
    input  logic [crcd_pkg::BYTE_W-1:0] rd_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [crcd_pkg::BYTE_W-1:0] out_id,
    output logic [crcd_pkg::BYTE_W-1:0] out_command,
    output logic [crcd_pkg::LEN_W-1:0]  out_length,
    output logic [crcd_pkg::BYTE_W-1:0] out_payload,
    output logic [crcd_pkg::IDX_W-1:0]  out_index,
    output logic                        out_last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]                  state_reg, state_next;
    logic [crcd_pkg::LEN_W-1:0]  idx_reg, idx_next;
    logic [crcd_pkg::BYTE_W-1:0] id_reg, id_next;
    logic [crcd_pkg::BYTE_W-1:0] cmd_reg, cmd_next;
    logic [crcd_pkg::LEN_W-1:0]  len_reg, len_next;
    logic [crcd_pkg::BYTE_W-1:0] data_reg, data_next;
    logic [crcd_pkg::IDX_W-1:0]  oidx_reg, oidx_next;
    logic                        last_reg, last_next;
    logic [crcd_pkg::LEN_W-1:0]  idx_inc;

    assign idx_inc = idx_reg + 1'b1;

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        id_next    = id_reg;
        cmd_next   = cmd_reg;
        len_next   = len_reg;
        data_next  = data_reg;
        oidx_next  = oidx_reg;
        last_next  = last_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (job.start) begin
                    id_next  = job.id;
                    cmd_next = job.command;
                    len_next = job.length;
                    idx_next = '0;
                    if (job.length == '0) begin
                        data_next  = '0;
                        oidx_next  = '0;
                        last_next  = 1'b1;
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                data_next  = rd_data;
                oidx_next  = idx_reg[crcd_pkg::IDX_W-1:0];
                last_next  = (idx_inc == len_reg);
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_ready) begin
                    if (last_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_inc;
                        state_next = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg   <= id_next;
        cmd_reg  <= cmd_next;
        len_reg  <= len_next;
        data_reg <= data_next;
        oidx_reg <= oidx_next;
        last_reg <= last_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign rd_en       = (state_reg == ST_READ);
    assign rd_addr     = idx_reg[AW-1:0];
    assign out_valid   = (state_reg == ST_OUT);
    assign out_id      = id_reg;
    assign out_command = cmd_reg;
    assign out_length  = len_reg;
    assign out_payload = data_reg;
    assign out_index   = oidx_reg;
    assign out_last    = last_reg;

endmodule
